// File: src/dcl_pkg.sv
// ----------------------------------------------------------------------------
// dcl_pkg
// shared types for the density cluster labeler: controller states, status, register indices and commands
// ----------------------------------------------------------------------------
package dcl_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CORE_INIT,
    ST_CORE_SCAN,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_EXPAND,
    ST_NEXT_SEED,
    ST_EMIT
  } state_t;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_MINPTS = 1'b1;

  typedef struct packed {
    logic core_clear;   // reset per-point counter scan
    logic core_step;    // compare pair (a,b), advance
    logic seed_take;    // queue seed, open cluster
    logic pop;          // pop queue head
    logic expand_step;  // test neighbor j of popped point
    logic next_seed;    // advance seed index
    logic emit_step;    // advance emit pointer
    logic start;        // clear pass state
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic seed_done;
    logic seed_ok;
    logic queue_empty;
    logic head_core;
    logic expand_done;
    logic emit_done;
    logic label_ok;     // label read data matches the emit pointer
  } status_t;

endpackage

// File: src/dcl_ram.sv
// ----------------------------------------------------------------------------
// dcl_ram
// generic single-write RAM with registered read
// ----------------------------------------------------------------------------
module dcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/dcl_ctrl.sv
// ----------------------------------------------------------------------------
// dcl_ctrl
// sequencer for load, core scan, cluster expansion and label emit
// ----------------------------------------------------------------------------
module dcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_go,
  input  logic              out_take,
  input  dcl_pkg::status_t  sts,
  output dcl_pkg::state_t   state,
  output dcl_pkg::cmd_t     cmd
);
  dcl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dcl_pkg::ST_LOAD;
    else state_r <= state_nxt;
  end

  assign state = state_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      dcl_pkg::ST_LOAD: begin
        if (in_go) begin
          cmd.start = 1'b1;
          state_nxt = dcl_pkg::ST_CORE_INIT;
        end
      end
      dcl_pkg::ST_CORE_INIT: begin
        cmd.core_clear = 1'b1;
        state_nxt = dcl_pkg::ST_CORE_SCAN;
      end
      dcl_pkg::ST_CORE_SCAN: begin
        cmd.core_step = 1'b1;
        if (sts.scan_done) state_nxt = dcl_pkg::ST_SEED;
      end
      dcl_pkg::ST_SEED: begin
        if (sts.seed_done) state_nxt = dcl_pkg::ST_EMIT;
        else if (sts.seed_ok) begin
          cmd.seed_take = 1'b1;
          state_nxt = dcl_pkg::ST_POP;
        end else begin
          cmd.next_seed = 1'b1;
        end
      end
      dcl_pkg::ST_POP: begin
        if (sts.queue_empty) state_nxt = dcl_pkg::ST_NEXT_SEED;
        else begin
          cmd.pop = 1'b1;
          state_nxt = dcl_pkg::ST_POP_WAIT;
        end
      end
      dcl_pkg::ST_POP_WAIT: begin
        if (sts.head_core) state_nxt = dcl_pkg::ST_EXPAND;
        else state_nxt = dcl_pkg::ST_POP;
      end
      dcl_pkg::ST_EXPAND: begin
        cmd.expand_step = 1'b1;
        if (sts.expand_done) state_nxt = dcl_pkg::ST_POP;
      end
      dcl_pkg::ST_NEXT_SEED: begin
        cmd.next_seed = 1'b1;
        state_nxt = dcl_pkg::ST_SEED;
      end
      dcl_pkg::ST_EMIT: begin
        if (out_take) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_done) state_nxt = dcl_pkg::ST_LOAD;
        end
      end
      default: state_nxt = dcl_pkg::ST_LOAD;
    endcase
  end
endmodule

// File: src/dcl_dp.sv
// ----------------------------------------------------------------------------
// dcl_dp
// point store, pairwise distance pipeline, core flags, queue and labels
// ----------------------------------------------------------------------------
module dcl_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dcl_pkg::state_t    state,
  input  dcl_pkg::cmd_t      cmd,
  input  logic               load_we,
  input  logic [47:0]        load_data,
  input  logic [15:0]        radius,
  input  logic [6:0]         min_points,
  output dcl_pkg::status_t   sts,
  output logic [5:0]         point_index,
  output logic [5:0]         cluster_number,
  output logic               is_noise,
  output logic               end_of_labels
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count_r;      // points loaded
  logic [CW-1:0] a_r;          // outer index (core scan / emit / seed)
  logic [CW-1:0] b_r;          // inner index
  logic [CW-1:0] head_r, tail_r;
  logic [CW-1:0] clus_r;
  logic [AW-1:0] p_r;          // popped point
  logic [CW-1:0] nb_r;         // neighbor count
  logic [MAX_POINTS-1:0] core_r, visit_r, member_r;
  logic          head_v_r;

  // two copies of the coordinate store so both pair members read in the same cycle
  logic [AW-1:0] ra_addr, rb_addr, waddr;
  logic [47:0]   ra_data, rb_data;

  assign waddr = count_r[AW-1:0];

  dcl_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_coord_a (
    .clk(clk), .we(load_we), .waddr(waddr), .wdata(load_data),
    .raddr(ra_addr), .rdata(ra_data));
  dcl_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_coord_b (
    .clk(clk), .we(load_we), .waddr(waddr), .wdata(load_data),
    .raddr(rb_addr), .rdata(rb_data));

  // queue memory
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata, q_rdata;
  dcl_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[AW-1:0]), .rdata(q_rdata));

  // label cluster numbers
  logic          l_we;
  logic [AW-1:0] l_waddr;
  logic [5:0]    l_rdata;
  dcl_ram #(.WIDTH(6), .DEPTH(MAX_POINTS)) u_label (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(clus_r[5:0]),
    .raddr(a_r[AW-1:0]), .rdata(l_rdata));

  // during scan: pair (a,b); during expand: pair (p,b)
  assign ra_addr = (state == dcl_pkg::ST_EXPAND) ? p_r : a_r[AW-1:0];
  assign rb_addr = b_r[AW-1:0];

  // stage 1: read issued; stage 2: diffs squared, with the sum compare on the squares
  logic          s1_v_r, s2_v_r;
  logic [AW-1:0] s1_a_r, s1_b_r, s2_a_r, s2_b_r;
  logic          s1_last_r, s2_last_r;
  logic [33:0]   sq_r [3];
  logic [31:0]   rsq_r;
  logic          hit;

  always_comb begin
    logic [35:0] sum;
    sum = {2'b0, sq_r[0]} + {2'b0, sq_r[1]} + {2'b0, sq_r[2]};
    hit = sum <= {4'b0, rsq_r};
  end

  // scan stops issuing once every row is done, expand once every neighbor is
  logic issue;
  logic [CW-1:0] last_b;
  assign last_b = count_r - CW'(1);
  assign issue = (cmd.core_step && (a_r < count_r)) ||
                 (cmd.expand_step && (b_r < count_r));

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      logic signed [16:0] df;
      df = 17'(signed'(ra_data[16*d +: 16])) - 17'(signed'(rb_data[16*d +: 16]));
      sq_r[d] <= 34'(df * df);
    end
    rsq_r <= 32'(radius) * 32'(radius);
    s1_a_r <= ra_addr;
    s1_b_r <= rb_addr;
    s2_a_r <= s1_a_r;
    s2_b_r <= s1_b_r;
    s1_last_r <= issue && (b_r == last_b) &&
                 (cmd.expand_step || a_r == last_b);
    s2_last_r <= s1_last_r;
  end

  logic [6:0] need;
  assign need = (min_points == 7'd0) ? 7'd1 : min_points;

  // expansion write of neighbor at s2_b
  logic exp_add;
  assign exp_add = s2_v_r && (state == dcl_pkg::ST_EXPAND) && hit &&
                   !visit_r[s2_b_r] && (tail_r < CW'(MAX_POINTS));

  always_comb begin
    q_we = 1'b0; q_waddr = tail_r[AW-1:0]; q_wdata = s2_b_r;
    l_we = 1'b0; l_waddr = s2_b_r;
    if (cmd.seed_take) begin
      // seed opens an empty queue at entry zero
      q_we = 1'b1; q_waddr = '0; q_wdata = a_r[AW-1:0];
      l_we = 1'b1; l_waddr = a_r[AW-1:0];
    end else if (exp_add) begin
      q_we = 1'b1; l_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      head_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (load_we) count_r <= count_r + CW'(1);
      else if (cmd.emit_step && sts.emit_done) count_r <= '0;
      if (cmd.start) begin
        visit_r <= '0; member_r <= '0; core_r <= '0;
        clus_r <= '0; a_r <= '0;
      end
      if (cmd.core_clear) begin
        a_r <= '0; b_r <= '0; nb_r <= '0;
      end
      if (cmd.core_step && issue) begin
        if (b_r == last_b) begin
          b_r <= '0;
          a_r <= a_r + CW'(1);
        end else b_r <= b_r + CW'(1);
      end
      // accumulate neighbors for core flags (scan pipeline)
      if (s2_v_r && state == dcl_pkg::ST_CORE_SCAN) begin
        logic [CW-1:0] nc;
        nc = (s2_b_r == '0) ? CW'(hit) : nb_r + CW'(hit);
        nb_r <= nc;
        if (s2_b_r == last_b[AW-1:0]) core_r[s2_a_r] <= ({1'b0, nc} >= (CW+1)'(need));
      end
      if (cmd.core_step && state == dcl_pkg::ST_CORE_SCAN && s2_last_r) a_r <= '0;
      if (cmd.next_seed) a_r <= a_r + CW'(1);
      if (cmd.seed_take) begin
        visit_r[a_r[AW-1:0]] <= 1'b1;
        member_r[a_r[AW-1:0]] <= 1'b1;
        head_r <= '0;
        tail_r <= CW'(1);
      end
      if (cmd.pop) begin
        head_r <= head_r + CW'(1);
        head_v_r <= 1'b1;
        b_r <= '0;
      end else head_v_r <= 1'b0;
      if (head_v_r) p_r <= q_rdata;
      if (cmd.expand_step && issue) b_r <= b_r + CW'(1);
      if (exp_add) begin
        visit_r[s2_b_r] <= 1'b1;
        member_r[s2_b_r] <= 1'b1;
        tail_r <= tail_r + CW'(1);
      end
      if (state == dcl_pkg::ST_NEXT_SEED) clus_r <= clus_r + CW'(1);
      if (state == dcl_pkg::ST_SEED && sts.seed_done) a_r <= '0;
      if (cmd.emit_step) a_r <= (a_r == last_b) ? '0 : a_r + CW'(1);
    end
  end

  // p_r is needed in POP_WAIT: take it straight from queue data
  logic [AW-1:0] head_pt;
  assign head_pt = q_rdata;

  assign sts.scan_done   = s2_last_r && s2_v_r;
  assign sts.seed_done   = a_r >= count_r;
  assign sts.seed_ok     = !visit_r[a_r[AW-1:0]] && core_r[a_r[AW-1:0]];
  assign sts.queue_empty = head_r >= tail_r;
  assign sts.head_core   = core_r[head_pt];
  assign sts.expand_done = s2_v_r && s2_last_r;

  // emit: label read is registered, data is good once the registered index matches the address
  logic [CW-1:0] emit_idx_r;
  always_ff @(posedge clk) begin
    emit_idx_r <= a_r;
  end
  assign sts.label_ok    = (state == dcl_pkg::ST_EMIT) && (emit_idx_r == a_r);
  assign sts.emit_done   = a_r == last_b;
  assign point_index     = 6'(a_r);
  assign cluster_number  = member_r[a_r[AW-1:0]] ? l_rdata : 6'd0;
  assign is_noise        = !member_r[a_r[AW-1:0]];
  assign end_of_labels   = a_r == last_b;
endmodule

// File: src/density_cluster_labeler_core.sv
// a final point starts a pass: core scan over every point pair, then expansion from each seed;
// the labels are read out after the pass
// throughput: points load one per cycle while loading; a label read separates taken labels, and
// a stalled label is held; the pass time is set by the single pairwise distance pipeline
// reset: rst_n synchronous, clears point count, control state and registers to radius 256,
// min points 4; stores need no clearing
// ----------------------------------------------------------------------------
// density_cluster_labeler_core
// density clustering of up to MAX_POINTS 3d points with one label per point
// ----------------------------------------------------------------------------
module density_cluster_labeler_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // point requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic signed [15:0] in_z_coord,
  input  logic        in_final_point,
  // label requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_point_index,
  output logic [5:0]  out_cluster_number,
  output logic        out_is_noise,
  output logic        out_end_of_labels,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CW = $clog2(MAX_POINTS + 1);

  dcl_pkg::state_t  state;
  dcl_pkg::cmd_t    cmd;
  dcl_pkg::status_t sts;

  logic [15:0] radius_r;
  logic [6:0]  minpts_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      minpts_r <= 7'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcl_pkg::CFG_RADIUS: radius_r <= cfg_data;
        dcl_pkg::CFG_MINPTS: minpts_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // accept points only while loading; drop once full
  logic in_take;
  logic [CW-1:0] cnt_r;
  assign in_stall = state != dcl_pkg::ST_LOAD;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (state == dcl_pkg::ST_EMIT && cmd.emit_step && sts.emit_done) cnt_r <= '0;
    else if (in_take && cnt_r < CW'(MAX_POINTS)) cnt_r <= cnt_r + CW'(1);
  end

  // the final point is stored unless full and always starts a pass
  logic go;
  assign go = in_take && in_final_point;

  logic emit_ok;
  assign out_valid = state == dcl_pkg::ST_EMIT && emit_ok;
  assign emit_ok   = sts.label_ok;

  dcl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_go(go), .out_take(out_valid && !out_stall),
    .sts(sts), .state(state), .cmd(cmd));

  dcl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .state(state), .cmd(cmd),
    .load_we(in_take && cnt_r < CW'(MAX_POINTS)),
    .load_data({in_z_coord, in_y_coord, in_x_coord}),
    .radius(radius_r), .min_points(minpts_r), .sts(sts),
    .point_index(out_point_index), .cluster_number(out_cluster_number),
    .is_noise(out_is_noise), .end_of_labels(out_end_of_labels));
endmodule

// File: src/dcl_checker.sv
// ----------------------------------------------------------------------------
// dcl_checker
// port-level checks for the density cluster labeler
// ----------------------------------------------------------------------------
module dcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_point_index,
  input logic       out_end_of_labels
);
  // labels and point intake never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("label while loading");

  // stalled label holds its index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_index))
    else $error("label changed under stall");

  // after the last label the block loads again
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_end_of_labels |=> !out_valid)
    else $error("labels past end");

  // indices advance by one, with a label read between each taken label and the next
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_end_of_labels |=> !out_valid ##1 (out_valid &&
    out_point_index == $past(out_point_index, 2) + 6'd1))
    else $error("index skipped");
endmodule

bind density_cluster_labeler_core dcl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_point_index(out_point_index), .out_end_of_labels(out_end_of_labels));

// File: verif/density_cluster_labeler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// density_cluster_labeler_core_tb
// loads random and directed point sets, predicts the density clusters of each
// set and checks every label that leaves the block, in order
// ----------------------------------------------------------------------------
module density_cluster_labeler_core_tb;

  localparam int NPTS = 64;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } point_req_t;

  typedef struct packed {
    logic [5:0] idx;
    logic [5:0] clus;
    logic       noise;
    logic       eol;
  } label_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_x_coord = '0;
  logic signed [15:0] in_y_coord = '0;
  logic signed [15:0] in_z_coord = '0;
  logic in_final_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_point_index;
  logic [5:0] out_cluster_number;
  logic out_is_noise;
  logic out_end_of_labels;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = dcl_pkg::CFG_RADIUS;
  logic [15:0] cfg_data = '0;

  density_cluster_labeler_core #(.MAX_POINTS(NPTS)) DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state: point store and active registers
  logic signed [15:0] px[NPTS], py[NPTS], pz[NPTS];
  int unsigned n_loaded = 0;
  int unsigned eps = 256;
  int unsigned min_pts = 4;

  point_req_t pending_points[$];
  label_t expected_labels[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 75;
  bit in_took = 1'b0;

  function automatic void add_point(point_req_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  function automatic bit near(int a, int b);
    longint dx, dy, dz;
    longint unsigned sum, r2;
    dx = longint'(px[a]) - longint'(px[b]);
    dy = longint'(py[a]) - longint'(py[b]);
    dz = longint'(pz[a]) - longint'(pz[b]);
    sum = dx * dx + dy * dy + dz * dz;
    r2 = longint'(eps) * longint'(eps);
    return sum <= r2;
  endfunction

  function automatic bit dense(int p, int n);
    int cnt;
    cnt = 0;
    for (int j = 0; j < n; j++) if (near(p, j)) cnt++;
    return cnt >= min_pts;
  endfunction

  // stores an accepted point; on the final one, clusters and queues labels
  task automatic predict_labels(point_req_t p);
    bit seen[NPTS];
    bit member[NPTS];
    int clus_of[NPTS];
    int bfs[$];
    int n, cid, q;
    if (n_loaded < NPTS) begin
      px[n_loaded] = p.x; py[n_loaded] = p.y; pz[n_loaded] = p.z;
      n_loaded++;
    end
    if (!p.last) return;
    n = n_loaded;
    cid = 0;
    for (int i = 0; i < NPTS; i++) begin
      seen[i] = 0; member[i] = 0; clus_of[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (seen[i] || !dense(i, n)) continue;
      seen[i] = 1; member[i] = 1; clus_of[i] = cid;
      bfs = {i};
      while (bfs.size() > 0) begin
        q = bfs.pop_front();
        if (!dense(q, n)) continue;
        for (int j = 0; j < n; j++) begin
          if (!seen[j] && near(q, j)) begin
            seen[j] = 1; member[j] = 1; clus_of[j] = cid;
            bfs.insert(bfs.size(), j);
          end
        end
      end
      cid++;
    end
    for (int k = 0; k < n; k++)
      expected_labels.insert(expected_labels.size(),
                             '{idx: 6'(k), clus: member[k] ? 6'(clus_of[k]) : 6'd0,
                               noise: !member[k], eol: (k + 1 == n)});
    n_loaded = 0;
  endtask

  // driver: one request on the input channel, payload held while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      // in_took tells whether the request was taken at the last rising edge
      if (!in_valid || in_took) begin
        if (pending_points.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {in_x_coord, in_y_coord, in_z_coord, in_final_point} <= pending_points.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // monitor: predict on accepted points, check accepted labels
  always @(posedge clk) begin
    label_t got, exp_l;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took)
        predict_labels({in_x_coord, in_y_coord, in_z_coord, in_final_point});
      if (out_valid && !out_stall) begin
        got = '{out_point_index, out_cluster_number, out_is_noise, out_end_of_labels};
        if (expected_labels.size() == 0) begin
          $display("%0t unexpected label: expected none actual %p", $time, got);
          errors++;
        end else begin
          exp_l = expected_labels.pop_front();
          if (got.idx !== exp_l.idx)
            $display("%0t point_index: expected %0d actual %0d", $time, exp_l.idx, got.idx);
          if (got.clus !== exp_l.clus)
            $display("%0t cluster_number: expected %0d actual %0d",
                     $time, exp_l.clus, got.clus);
          if (got.noise !== exp_l.noise)
            $display("%0t is_noise: expected %0d actual %0d", $time, exp_l.noise, got.noise);
          if (got.eol !== exp_l.eol)
            $display("%0t end_of_labels: expected %0d actual %0d", $time, exp_l.eol, got.eol);
          if (got !== exp_l) errors++;
        end
      end
    end else begin
      in_took = 1'b0;
    end
  end

  // wait until every queued point is taken and every label is back
  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_labels.size() > 0)
      @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == dcl_pkg::CFG_RADIUS) eps = val & 16'hFFFF;
    else min_pts = val & 7'h7F;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_coord(int center, int spread);
    return 16'(center + $urandom_range(2 * spread, 0) - spread);
  endfunction

  // a set of blobs around random centers plus scattered noise
  task automatic queue_blob_set(int n, int spread);
    int cx, cy, cz, blobs;
    point_req_t p;
    blobs = $urandom_range(3, 1);
    for (int i = 0; i < n; i++) begin
      if (i % ((n + blobs - 1) / blobs) == 0) begin
        cx = $urandom_range(65535, 0) - 32768;
        cy = $urandom_range(65535, 0) - 32768;
        cz = $urandom_range(65535, 0) - 32768;
      end
      if ($urandom_range(9, 0) == 0)
        p = '{16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
      else
        p = '{rnd_coord(cx, spread), rnd_coord(cy, spread), rnd_coord(cz, spread), 1'b0};
      p.last = (i == n - 1);
      add_point(p);
    end
  endtask

  task automatic random_phase(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 30) : $urandom_range(12, 1);
      queue_blob_set(n, $urandom_range(600, 50));
      sent += n;
      if ($urandom_range(3, 0) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: coordinate extremes with reset registers
    add_point('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0});
    add_point('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0});
    add_point('{16'sh0000, 16'sh0000, 16'sh0000, 1'b0});
    add_point('{16'sh0040, 16'sh0000, 16'sh0000, 1'b0});
    add_point('{16'sh0000, 16'sh0040, 16'sh0000, 1'b0});
    add_point('{16'sh0000, 16'sh0000, 16'sh0100, 1'b1});
    // a lone point set
    add_point('{16'sh1234, 16'shEDCB, 16'sh5555, 1'b1});
    // sender holds off until every label is back
    drain();

    // radius 0, min points 1: every distinct point its own cluster
    write_reg(dcl_pkg::CFG_RADIUS, 0);
    write_reg(dcl_pkg::CFG_MINPTS, 1);
    add_point('{16'sh0100, 16'sh0100, 16'sh0100, 1'b0});
    add_point('{16'sh0100, 16'sh0100, 16'sh0100, 1'b0});
    add_point('{16'shAAAA, 16'sh5555, 16'shFFFF, 1'b1});
    drain();

    // maximal radius and min points 0 (treated as one)
    write_reg(dcl_pkg::CFG_RADIUS, 65535);
    write_reg(dcl_pkg::CFG_MINPTS, 0);
    add_point('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0});
    add_point('{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1});
    drain();

    // min points 64 and 127 with a full store plus dropped points
    write_reg(dcl_pkg::CFG_MINPTS, 64);
    queue_blob_set(NPTS, 20);
    drain();
    write_reg(dcl_pkg::CFG_MINPTS, 127);
    for (int i = 0; i < NPTS + 3; i++)
      add_point('{16'(i), 16'(-i), 16'(i * 3), i == NPTS + 2});
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 13 : 0;
      write_reg(dcl_pkg::CFG_RADIUS, $urandom_range(900, 60));
      write_reg(dcl_pkg::CFG_MINPTS, $urandom_range(6, 1));
      random_phase(50);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
